// ===== hdl/horizontal_area_downscale_unit_defines.svh =====
// Assertion shorthands used by the downscaler sequencer RTL.
// Each macro expects i_clk and i_rst_n in the module that uses it.
`ifndef HORIZONTAL_AREA_DOWNSCALE_UNIT_DEFINES_SVH
`define HORIZONTAL_AREA_DOWNSCALE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HAD_ASSERT_IMPL(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("downscaler check failed");

// Next-cycle implication, checked out of reset.
`define HAD_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("downscaler check failed");

`endif

// ===== hdl/had_pkg.sv =====
`default_nettype none

package had_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int SRC_W      = 13;
    localparam int TGT_W      = 12;
    localparam int SUM_W      = 21;
    localparam int WTOT_W     = 26;
    localparam int NUM_W      = 33;
    localparam int NUM_CH     = 3;
    localparam int QUO_STEPS  = 8;
    localparam int INIT_STEPS = SRC_W;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_SRC = 2'd0;
    localparam logic [1:0] CFG_TGT = 2'd1;

    typedef struct packed {
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       line_done;
    } t_pix_out;

    typedef struct packed {
        logic init_load;
        logic init_step;
        logic restart;
        logic accept;
        logic mul1;
        logic div1_step;
        logic mul2;
        logic sat;
        logic div2_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic boundary;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hdl/horizontal_area_downscale_unit.sv =====
`default_nettype none

// Horizontal area-averaging downscaler for BGR scan lines. Pixels enter one
// item at a time and each line of source_width pixels is narrowed to
// target_width-1 output items, the last flagged by line_done. A pixel that
// lies wholly inside one output pixel is accepted without leaving the idle state. A
// pixel that straddles an output boundary holds input ready low while two 8-step
// restoring dividers per channel run (the split of the pixel, then the channel
// average), each after a multiply step, with a saturation check before the
// second, and while the block waits for the output register to free up. After
// reset and after each write to source_width or target_width the block holds
// input ready low while it divides source_width by target_width one bit a cycle
// to set up the boundary stepping. Writes to other register indexes are ignored.
// Widths out of range are clamped. Output channels saturate at 255.
module horizontal_area_downscale_unit import had_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [SRC_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_pix_in          i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_pix_out              o_out_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer: geometry setup, per-pixel accept and the boundary pipeline.
    had_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // Registers, accumulators, dividers and the output register.
    had_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_pix       (o_out_data),
        .o_valid     (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule

`default_nettype wire

// ===== hdl/had_dp.sv =====
`default_nettype none

module had_dp import had_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [SRC_W-1:0]  i_cfg_data,
    input  wire t_pix_in           i_pix,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    output t_pix_out               o_pix,
    output logic                   o_valid,
    input  wire logic              i_out_ready
);

    logic [SRC_W-1:0]  r_src;
    logic [TGT_W-1:0]  r_tgt;
    logic [SRC_W-1:0]  s_eff;
    logic [TGT_W-1:0]  t_eff;
    logic [TGT_W-1:0]  t_one;
    logic [SRC_W-1:0]  s_less;

    // Line geometry divider: source width over target width, one bit a cycle.
    logic [SRC_W-1:0]  r_iq;
    logic [SRC_W-1:0]  r_ir;
    logic [SRC_W-1:0]  init_trial;
    logic              init_ge;

    // Line state.
    logic [SRC_W-1:0]  r_pos;
    logic [SRC_W-1:0]  r_bnd;
    logic [SRC_W-1:0]  r_split;
    logic [TGT_W-1:0]  r_srem;
    logic [SUM_W-1:0]  r_sum  [NUM_CH];
    logic [WTOT_W-1:0] r_wtot;

    // Boundary pixel pipeline.
    logic [7:0]        r_pix  [NUM_CH];
    logic [TGT_W-1:0]  r_wt;
    logic [WTOT_W-1:0] r_n;
    logic              r_last;
    logic [TGT_W-1:0]  r_rem1 [NUM_CH];
    logic [7:0]        r_low1 [NUM_CH];
    logic [7:0]        r_q1   [NUM_CH];
    logic [NUM_W-1:0]  r_num  [NUM_CH];
    logic [WTOT_W-1:0] r_rem2 [NUM_CH];
    logic [7:0]        r_low2 [NUM_CH];
    logic [7:0]        r_q2   [NUM_CH];
    logic              r_sat  [NUM_CH];
    t_pix_out          r_out;
    logic              r_out_valid;

    logic [7:0]        pix_in [NUM_CH];
    logic              active;
    logic              at_end;
    logic [SRC_W-1:0]  srem_sum;
    logic              srem_carry;
    logic [TGT_W-1:0]  srem_next;
    logic [7:0]        res    [NUM_CH];

    assign pix_in[0] = i_pix.in_blue;
    assign pix_in[1] = i_pix.in_green;
    assign pix_in[2] = i_pix.in_red;

    always_comb begin
        if (r_src < SRC_W'(2)) begin
            s_eff = SRC_W'(2);
        end else if (r_src > SRC_W'(MAX_WIDTH)) begin
            s_eff = SRC_W'(MAX_WIDTH);
        end else begin
            s_eff = r_src;
        end
        s_less = s_eff - SRC_W'(1);
        t_one  = (r_tgt == '0) ? TGT_W'(1) : r_tgt;
        t_eff  = ({1'b0, t_one} > s_less) ? s_less[TGT_W-1:0] : t_one;
    end

    assign init_trial = {r_ir[TGT_W-1:0], r_iq[SRC_W-1]};
    assign init_ge    = init_trial >= {1'b0, t_eff};

    assign active     = r_bnd < {1'b0, t_eff};
    assign at_end     = (r_pos + SRC_W'(1)) >= s_eff;
    assign srem_sum   = {1'b0, r_srem} + {1'b0, r_ir[TGT_W-1:0]};
    assign srem_carry = srem_sum >= {1'b0, t_eff};
    assign srem_next  = srem_carry ? TGT_W'(srem_sum - {1'b0, t_eff})
                                   : srem_sum[TGT_W-1:0];

    assign o_sts.boundary = active && (r_pos >= r_split);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= SRC_W'(2);
            r_tgt <= TGT_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SRC) begin
                r_src <= i_cfg_data;
            end else if (i_cfg_idx == CFG_TGT) begin
                r_tgt <= i_cfg_data[TGT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_load) begin
            r_iq <= s_eff;
            r_ir <= '0;
        end else if (i_cmd.init_step) begin
            r_iq <= {r_iq[SRC_W-2:0], init_ge};
            r_ir <= init_ge ? (init_trial - {1'b0, t_eff}) : init_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.restart || (i_cmd.accept && at_end)) begin
            r_pos   <= '0;
            r_bnd   <= SRC_W'(1);
            r_split <= r_iq;
            r_srem  <= r_ir[TGT_W-1:0];
            r_wtot  <= '0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_sum[c] <= '0;
            end
        end else if (i_cmd.accept) begin
            r_pos <= r_pos + SRC_W'(1);
            if (o_sts.boundary) begin
                r_wtot  <= WTOT_W'(t_eff - r_srem);
                r_bnd   <= r_bnd + SRC_W'(1);
                r_split <= r_split + r_iq + SRC_W'(srem_carry);
                r_srem  <= srem_next;
            end else if (active) begin
                r_wtot <= r_wtot + WTOT_W'(t_eff);
                for (int c = 0; c < NUM_CH; c++) begin
                    r_sum[c] <= r_sum[c] + SUM_W'(pix_in[c]);
                end
            end
        end else if (i_cmd.mul2) begin
            // The right part of the split pixel opens the next sum.
            for (int c = 0; c < NUM_CH; c++) begin
                r_sum[c] <= SUM_W'(r_pix[c] - r_q1[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_pix[c] <= pix_in[c];
            end
            r_wt   <= r_srem;
            r_n    <= r_wtot + WTOT_W'(r_srem);
            r_last <= (r_bnd + SRC_W'(1)) >= {1'b0, t_eff};
        end
        for (int c = 0; c < NUM_CH; c++) begin
            logic [19:0]       prod;
            logic [TGT_W:0]    t1;
            logic              ge1;
            logic [WTOT_W:0]   t2;
            logic              ge2;
            prod = 20'(r_wt * r_pix[c]);
            t1   = {r_rem1[c], r_low1[c][7]};
            ge1  = t1 >= {1'b0, t_eff};
            t2   = {r_rem2[c], r_low2[c][7]};
            ge2  = t2 >= {1'b0, r_n};
            if (i_cmd.mul1) begin
                r_rem1[c] <= prod[19:8];
                r_low1[c] <= prod[7:0];
            end else if (i_cmd.div1_step) begin
                r_rem1[c] <= ge1 ? TGT_W'(t1 - {1'b0, t_eff}) : t1[TGT_W-1:0];
                r_low1[c] <= {r_low1[c][6:0], 1'b0};
                r_q1[c]   <= {r_q1[c][6:0], ge1};
            end
            if (i_cmd.mul2) begin
                r_num[c] <= NUM_W'(t_eff * (r_sum[c] + SUM_W'(r_q1[c])));
            end
            if (i_cmd.sat) begin
                r_sat[c]  <= {1'b0, r_num[c]} >= {r_n, 8'd0};
                r_rem2[c] <= {1'b0, r_num[c][NUM_W-1:8]};
                r_low2[c] <= r_num[c][7:0];
            end else if (i_cmd.div2_step) begin
                r_rem2[c] <= ge2 ? WTOT_W'(t2 - {1'b0, r_n}) : t2[WTOT_W-1:0];
                r_low2[c] <= {r_low2[c][6:0], 1'b0};
                r_q2[c]   <= {r_q2[c][6:0], ge2};
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (r_n == '0) begin
                res[c] = '0;
            end else if (r_sat[c]) begin
                res[c] = 8'hFF;
            end else begin
                res[c] = r_q2[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.out_blue  <= res[0];
            r_out.out_green <= res[1];
            r_out.out_red   <= res[2];
            r_out.line_done <= r_last;
        end
    end

    assign o_pix   = r_out;
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hdl/had_ctrl.sv =====
`default_nettype none
`include "horizontal_area_downscale_unit_defines.svh"

module had_ctrl import had_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_dp_sts    i_sts,
    output t_dp_cmd         o_cmd
);

    localparam logic [3:0] S_LOAD    = 4'd0;
    localparam logic [3:0] S_INIT    = 4'd1;
    localparam logic [3:0] S_RESTART = 4'd2;
    localparam logic [3:0] S_IDLE    = 4'd3;
    localparam logic [3:0] S_MUL1    = 4'd4;
    localparam logic [3:0] S_DIV1    = 4'd5;
    localparam logic [3:0] S_MUL2    = 4'd6;
    localparam logic [3:0] S_SAT     = 4'd7;
    localparam logic [3:0] S_DIV2    = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [3:0] r_cnt;
    logic [3:0] n_cnt;
    logic       cfg_hit;

    // Only a write to one of the listed registers touches the line state.
    assign cfg_hit = i_cfg_we && (i_cfg_idx inside {CFG_SRC, CFG_TGT});

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_cmd.init_load = 1'b1;
                n_cnt   = '0;
                n_state = S_INIT;
            end
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(INIT_STEPS - 1)) begin
                    n_state = S_RESTART;
                end
            end
            S_RESTART: begin
                o_cmd.restart = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.boundary) begin
                        n_state = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV1;
            end
            S_DIV1: begin
                o_cmd.div1_step = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(QUO_STEPS - 1)) begin
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_SAT;
            end
            S_SAT: begin
                o_cmd.sat = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div2_step = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(QUO_STEPS - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
        // A write to either width register recomputes the line geometry from scratch.
        if (cfg_hit) begin
            n_state = S_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `HAD_ASSERT_NEXT(a_cfg_reload, cfg_hit, r_state == S_LOAD)
    `HAD_ASSERT_IMPL(a_out_slot, o_cmd.out_load, i_sts.out_free)
    `HAD_ASSERT_IMPL(a_div_cnt, r_state == S_DIV1 || r_state == S_DIV2, r_cnt < 4'(QUO_STEPS))
    `HAD_ASSERT_NEXT(a_bnd_start, o_cmd.accept && i_sts.boundary && !cfg_hit, r_state == S_MUL1)

endmodule

`default_nettype wire
